>>> src/keypad_code_lock_controller_macros.svh
// Assertion macros shared by the keypad code lock checker.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KCLC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KCLC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/kclc_pkg.sv
// Types, codes and constants of the keypad code lock controller.
package kclc_pkg;

    // Lock modes, as reported in the result
    typedef enum logic [3:0] {
        M_IDLE,
        M_ENTRY,
        M_OLD,
        M_NEW,
        M_RESET,
        M_AUTH,
        M_ID,
        M_OPEN,
        M_LOCKOUT,
        M_PERM
    } t_mode;

    // Event codes reported with each result
    typedef enum logic [3:0] {
        E_NONE,
        E_OPENED,
        E_WRONG,
        E_CHANGED,
        E_RESET,
        E_ENROL,
        E_DELETE,
        E_LOCKOUT,
        E_LOCKED
    } t_event;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        CMD_KEY,
        CMD_TICK,
        CMD_FINGER,
        CMD_REMOTE
    } t_cmd;

    // Configuration register indexes
    localparam logic [2:0] CFG_MASTER  = 3'd0;
    localparam logic [2:0] CFG_DEFAULT = 3'd1;
    localparam logic [2:0] CFG_OPEN    = 3'd2;
    localparam logic [2:0] CFG_SHORT   = 3'd3;
    localparam logic [2:0] CFG_LONG    = 3'd4;

    // Key codes
    localparam logic [3:0] KEY_A    = 4'd10;
    localparam logic [3:0] KEY_B    = 4'd11;
    localparam logic [3:0] KEY_C    = 4'd12;
    localparam logic [3:0] KEY_D    = 4'd13;
    localparam logic [3:0] KEY_STAR = 4'd14;
    localparam logic [3:0] KEY_HASH = 4'd15;

    // Remote bytes
    localparam logic [7:0] REMOTE_OPEN  = 8'd97;
    localparam logic [7:0] REMOTE_CLOSE = 8'd122;

    // Failure thresholds
    localparam logic [2:0] FAIL_SHORT = 3'd3;
    localparam logic [2:0] FAIL_LONG  = 3'd4;
    localparam logic [2:0] FAIL_MAX   = 3'd5;

    // Defaults after reset
    localparam int          CODE_KEYS_DEF     = 6;
    localparam logic [23:0] MASTER_PW_RST     = 24'h111111;
    localparam logic [23:0] DEFAULT_PW_RST    = 24'h123456;
    localparam logic [15:0] OPEN_TICKS_RST    = 16'd5000;
    localparam logic [15:0] SHORT_TICKS_RST   = 16'd10000;
    localparam logic [15:0] LONG_TICKS_RST    = 16'd20000;

    // Build a code of n keys alternating two keys, first key in nibble n-1 (top of the code)
    function automatic logic [31:0] alt_pattern(input int n, input logic [3:0] even_key,
                                                input logic [3:0] odd_key);
        logic [31:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                p = {p[27:0], ((i % 2) == 1) ? odd_key : even_key};
            end
        end
        return p;
    endfunction

endpackage

>>> src/keypad_code_lock_controller.sv
// Keypad code lock controller: event decode, lock state and result register.
//
// Requests arrive on the slave stream: tuser holds the kind (key, tick,
// fingerprint result, remote byte), tdata the key code, match flag and byte.
// Every accepted request yields exactly one result on the master stream:
// latch drive, mode, failure count, keys entered, event, ID and the ticks
// left in the door-open or lockout period.
// Configuration registers (master and default password, open, short and
// long lock ticks) are written on the cfg channel, which is always ready;
// write them only while no request is in flight.
// The result is registered: it goes into the result register, or into the skid register while the receiver stalls.
// Throughput: one request per cycle while the skid register is empty; the whole state update is one pass of
// logic from the stored state into the state and result registers.
// A result register and a one-entry skid register sit on the output, so the
// slave side stays ready while the receiver stalls until both are full,
// then tready drops until the receiver takes a result.
// Reset (synchronous, active low) sets idle mode, closed latch, zero fail
// count, the default stored password and the default configuration.
module keypad_code_lock_controller
    import kclc_pkg::*;
#(
    parameter int CODE_KEYS = CODE_KEYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave request stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata: key_code[3:0], finger_ok[4], remote_byte[12:5], zero [15:13]
    input  logic [15:0] i_s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  i_s_axis_tuser,
    // master result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata: latch_on[0], mode[4:1], fail_count[7:5], keys_entered[10:8],
    // event_res[14:11], request_id[18:15], remaining_ticks[34:19], zero [39:35]
    output logic [39:0] o_m_axis_tdata,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int CW = 4 * CODE_KEYS;
    localparam int KW = $clog2(CODE_KEYS);
    localparam logic [31:0] CODE_MASK = 32'({CW{1'b1}});
    localparam logic [CW-1:0] PAT_CHANGE = CW'(alt_pattern(CODE_KEYS, KEY_STAR, KEY_HASH));
    localparam logic [CW-1:0] PAT_RESET  = CW'(alt_pattern(CODE_KEYS, KEY_D, KEY_C));
    localparam logic [KW-1:0] LAST_KEY   = KW'(CODE_KEYS - 1);

    // configuration registers
    logic [23:0] r_master_pw;
    logic [23:0] r_default_pw;
    logic [15:0] r_open_ticks;
    logic [15:0] r_short_ticks;
    logic [15:0] r_long_ticks;

    // lock state
    t_mode       r_mode,     n_mode;
    logic [CW-1:0] r_code,   n_code;
    logic [KW-1:0] r_keys,   n_keys;
    logic [23:0] r_stored_pw, n_stored_pw;
    logic [2:0]  r_fails,    n_fails;
    logic [15:0] r_count,    n_count;
    logic        r_latch,    n_latch;
    logic        r_purpose,  n_purpose;

    // output and skid registers
    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_skid_valid;
    logic [39:0] r_skid_data;

    // request decode
    logic        s_accept;
    logic        m_take;
    t_cmd        req_cmd;
    logic [3:0]  req_key;
    logic        req_finger;
    logic [7:0]  req_byte;

    // combinational results of one request
    logic [CW-1:0] code_shift;
    logic [31:0] code_ext;
    logic        hit_stored;
    logic        hit_master;
    logic [2:0]  fail_cnt;
    t_mode       fail_mode;
    logic [15:0] fail_ticks;
    t_event      fail_event;
    logic [15:0] count_dec;
    t_event      res_event;
    logic [3:0]  res_id;
    logic [39:0] res_data;

    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_take          = r_out_valid && i_m_axis_tready;
    assign o_s_axis_tready = !r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_cfg_ready     = 1'b1;

    assign req_cmd    = t_cmd'(i_s_axis_tuser);
    assign req_key    = i_s_axis_tdata[3:0];
    assign req_finger = i_s_axis_tdata[4];
    assign req_byte   = i_s_axis_tdata[12:5];

    // shift the key in and compare the finished code
    assign code_shift = {r_code[CW-5:0], req_key};
    assign code_ext   = 32'(code_shift);
    assign hit_stored = code_ext == (32'(r_stored_pw) & CODE_MASK);
    assign hit_master = code_ext == (32'(r_master_pw) & CODE_MASK);
    assign count_dec  = (r_count != 16'd0) ? r_count - 16'd1 : 16'd0;

    // outcome of a failed code
    always_comb begin
        fail_cnt   = (r_fails < FAIL_MAX) ? r_fails + 3'd1 : r_fails;
        fail_ticks = r_count;
        if (fail_cnt == FAIL_SHORT) begin
            fail_mode  = M_LOCKOUT;
            fail_ticks = r_short_ticks;
            fail_event = E_LOCKOUT;
        end else if (fail_cnt == FAIL_LONG) begin
            fail_mode  = M_LOCKOUT;
            fail_ticks = r_long_ticks;
            fail_event = E_LOCKOUT;
        end else if (fail_cnt >= FAIL_MAX) begin
            fail_mode  = M_PERM;
            fail_event = E_LOCKED;
        end else begin
            fail_mode  = M_IDLE;
            fail_event = E_WRONG;
        end
    end

    // next state of the lock for the request at the input
    always_comb begin
        n_mode      = r_mode;
        n_code      = r_code;
        n_keys      = r_keys;
        n_stored_pw = r_stored_pw;
        n_fails     = r_fails;
        n_count     = r_count;
        n_latch     = r_latch;
        n_purpose   = r_purpose;
        res_event   = E_NONE;
        res_id      = 4'd0;
        case (req_cmd)
            CMD_KEY: begin
                case (r_mode)
                    M_IDLE: begin
                        n_code = '0;
                        n_keys = '0;
                        if (req_key == KEY_STAR) begin
                            n_mode = M_ENTRY;
                        end else if (req_key == KEY_D) begin
                            n_mode = M_RESET;
                        end else if (req_key == KEY_A) begin
                            n_mode    = M_AUTH;
                            n_purpose = 1'b0;
                        end else if (req_key == KEY_B) begin
                            n_mode    = M_AUTH;
                            n_purpose = 1'b1;
                        end
                    end
                    M_ENTRY, M_OLD, M_NEW, M_RESET, M_AUTH: begin
                        if (r_mode == M_ENTRY && req_key == KEY_C) begin
                            n_code = '0;
                            n_keys = '0;
                        end else if (r_keys != LAST_KEY) begin
                            n_code = code_shift;
                            n_keys = r_keys + 1'b1;
                        end else begin
                            // code complete: act on it and clear the entry
                            n_code = '0;
                            n_keys = '0;
                            case (r_mode)
                                M_ENTRY: begin
                                    if (code_shift == PAT_CHANGE) begin
                                        n_mode = M_OLD;
                                    end else if (hit_stored || hit_master) begin
                                        n_latch   = 1'b1;
                                        n_count   = r_open_ticks;
                                        n_mode    = M_OPEN;
                                        res_event = E_OPENED;
                                    end else begin
                                        n_fails   = fail_cnt;
                                        n_mode    = fail_mode;
                                        n_count   = fail_ticks;
                                        res_event = fail_event;
                                    end
                                end
                                M_OLD: begin
                                    if (hit_stored) begin
                                        n_mode = M_NEW;
                                    end else begin
                                        n_fails   = fail_cnt;
                                        n_mode    = fail_mode;
                                        n_count   = fail_ticks;
                                        res_event = fail_event;
                                    end
                                end
                                M_NEW: begin
                                    n_stored_pw = code_ext[23:0];
                                    n_mode      = M_IDLE;
                                    res_event   = E_CHANGED;
                                end
                                M_RESET: begin
                                    if (code_shift == PAT_RESET) begin
                                        n_stored_pw = r_default_pw;
                                        res_event   = E_RESET;
                                    end
                                    n_mode = M_IDLE;
                                end
                                default: begin
                                    if (hit_master) begin
                                        n_mode = M_ID;
                                    end else begin
                                        n_fails   = fail_cnt;
                                        n_mode    = fail_mode;
                                        n_count   = fail_ticks;
                                        res_event = fail_event;
                                    end
                                end
                            endcase
                        end
                    end
                    M_ID: begin
                        res_id    = req_key;
                        n_mode    = M_IDLE;
                        res_event = r_purpose ? E_DELETE : E_ENROL;
                    end
                    default: begin
                    end
                endcase
            end
            CMD_TICK: begin
                if (r_mode == M_OPEN || r_mode == M_LOCKOUT) begin
                    n_count = count_dec;
                    if (count_dec == 16'd0) begin
                        if (r_mode == M_OPEN) begin
                            n_latch = 1'b0;
                            n_fails = 3'd0;
                        end
                        n_mode = M_IDLE;
                    end
                end
            end
            CMD_FINGER: begin
                if (r_mode == M_IDLE || r_mode == M_PERM) begin
                    if (req_finger) begin
                        n_latch   = 1'b1;
                        n_count   = r_open_ticks;
                        n_mode    = M_OPEN;
                        res_event = E_OPENED;
                    end else begin
                        res_event = E_WRONG;
                    end
                end
            end
            default: begin
                if (r_mode == M_IDLE) begin
                    if (req_byte == REMOTE_OPEN) begin
                        n_latch   = 1'b1;
                        res_event = E_OPENED;
                    end else if (req_byte == REMOTE_CLOSE) begin
                        n_latch = 1'b0;
                    end
                end
            end
        endcase
        // drop the countdown outside timed modes
        if (n_mode != M_OPEN && n_mode != M_LOCKOUT) begin
            n_count = 16'd0;
        end
    end

    // pack the result of the request
    always_comb begin
        res_data        = '0;
        res_data[0]     = n_latch;
        res_data[4:1]   = n_mode;
        res_data[7:5]   = n_fails;
        res_data[10:8]  = 3'(n_keys);
        res_data[14:11] = res_event;
        res_data[18:15] = res_id;
        res_data[34:19] = n_count;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_pw   <= MASTER_PW_RST;
            r_default_pw  <= DEFAULT_PW_RST;
            r_open_ticks  <= OPEN_TICKS_RST;
            r_short_ticks <= SHORT_TICKS_RST;
            r_long_ticks  <= LONG_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MASTER:  r_master_pw   <= i_cfg_data;
                CFG_DEFAULT: r_default_pw  <= i_cfg_data;
                CFG_OPEN:    r_open_ticks  <= i_cfg_data[15:0];
                CFG_SHORT:   r_short_ticks <= i_cfg_data[15:0];
                CFG_LONG:    r_long_ticks  <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // lock state: advance on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_code      <= '0;
            r_keys      <= '0;
            r_stored_pw <= DEFAULT_PW_RST;
            r_fails     <= 3'd0;
            r_count     <= 16'd0;
            r_latch     <= 1'b0;
            r_purpose   <= 1'b0;
        end else if (s_accept) begin
            r_mode      <= n_mode;
            r_code      <= n_code;
            r_keys      <= n_keys;
            r_stored_pw <= n_stored_pw;
            r_fails     <= n_fails;
            r_count     <= n_count;
            r_latch     <= n_latch;
            r_purpose   <= n_purpose;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= s_accept;
            end
        end else if (s_accept) begin
            if (!r_out_valid) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // result payload: hold unless moved
    always_ff @(posedge i_clk) begin
        if (m_take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (s_accept) begin
                r_out_data <= res_data;
            end
        end else if (s_accept) begin
            if (!r_out_valid) begin
                r_out_data <= res_data;
            end else begin
                r_skid_data <= res_data;
            end
        end
    end

endmodule

>>> src/kclc_checker.sv
// Port-level checker of the keypad code lock controller, with its bind.
`include "keypad_code_lock_controller_macros.svh"

module kclc_checker
    import kclc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata
);

    logic        res_latch;
    logic [3:0]  res_mode;
    logic [2:0]  res_fails;
    logic [3:0]  res_event;
    logic [15:0] res_ticks;

    assign res_latch = o_m_axis_tdata[0];
    assign res_mode  = o_m_axis_tdata[4:1];
    assign res_fails = o_m_axis_tdata[7:5];
    assign res_event = o_m_axis_tdata[14:11];
    assign res_ticks = o_m_axis_tdata[34:19];

    // hold a stalled result
    `KCLC_ASSERT_NEXT(a_stall_hold, o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // a countdown only runs while open or locked out
    `KCLC_ASSERT_NOW(a_ticks_mode, o_m_axis_tvalid && res_ticks != 16'd0,
        res_mode == M_OPEN || res_mode == M_LOCKOUT, "ticks left outside timed mode")

    // the latch is driven whenever the door is open
    `KCLC_ASSERT_NOW(a_open_latch, o_m_axis_tvalid && res_mode == M_OPEN,
        res_latch, "open mode with latch closed")

    // permanent lock comes with a saturated fail count
    `KCLC_ASSERT_NOW(a_locked, o_m_axis_tvalid && res_event == E_LOCKED,
        res_mode == M_PERM && res_fails == FAIL_MAX, "lock event without permanent lock")

    // enrol and delete requests return to idle
    `KCLC_ASSERT_NOW(a_id_idle,
        o_m_axis_tvalid && (res_event == E_ENROL || res_event == E_DELETE),
        res_mode == M_IDLE, "ID request not back in idle")

endmodule

bind keypad_code_lock_controller kclc_checker u_kclc_checker (.*);
